// ----- sv/gbs_pkg.sv -----
// Package with payload words, register indexes and fixed field widths of the glyph scaler.
package gbs_pkg;

  localparam int SRC_W     = 7;
  localparam int DST_W     = 11;
  localparam int OPA_W     = 8;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 3;
  localparam int COORD_W   = 10;
  localparam int LOAD_W    = 12;
  localparam int ALPHA_W   = 8;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_DST_WIDTH  = 3'd2,
    REG_DST_HEIGHT = 3'd3,
    REG_OPACITY    = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic               mode;
    logic [LOAD_W-1:0]  load_index;
    logic [ALPHA_W-1:0] alpha_byte;
    logic [COORD_W-1:0] dst_x;
    logic [COORD_W-1:0] dst_y;
  } req_word_t;

  typedef struct packed {
    logic [7:0] coverage;
    logic       covered;
  } res_word_t;

  typedef struct packed {
    logic               mode;
    logic [LOAD_W-1:0]  load_index;
    logic [ALPHA_W-1:0] alpha_byte;
  } side_t;

endpackage

// ----- sv/gbs_ram.sv -----
// Generic single-write, dual-read RAM with registered read data.
module gbs_ram
  import gbs_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ----- sv/gbs_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with saturation flag.
module gbs_div
  import gbs_pkg::*;
#(
  parameter int NUM_W = 26,
  parameter int DEN_W = 12,
  parameter int QB    = 15
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QB-1:0]    q,
  output logic             sat
);

  localparam int CW = (NUM_W > DEN_W + QB) ? NUM_W : DEN_W + QB;

  logic [CW-1:0]    rem   [QB+1];
  logic [DEN_W-1:0] dreg  [QB+1];
  logic [QB-1:0]    qreg  [QB+1];
  logic             sreg  [QB+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= CW'(num);
      dreg[0] <= den;
      qreg[0] <= '0;
      sreg[0] <= 1'b0;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [CW-1:0] dsh;
    logic          take;
    logic          sat_in;
    assign dsh = CW'(dreg[k]) << (QB - 1 - k);
    assign take = rem[k] >= dsh;
    if (k == 0) begin : g_first
      assign sat_in = rem[0] >= (CW'(dreg[0]) << QB);
    end else begin : g_rest
      assign sat_in = sreg[k];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= take ? rem[k] - dsh : rem[k];
        dreg[k+1] <= dreg[k];
        qreg[k+1] <= qreg[k] | (QB'(take) << (QB - 1 - k));
        sreg[k+1] <= sat_in;
      end
    end
  end

  assign q   = qreg[QB];
  assign sat = sreg[QB];

endmodule

// ----- sv/glyph_bilinear_scaler.sv -----
// Top level of the glyph scaler: config registers, coordinate divide, mask store and blend.
// Samples pass input, divider, address, store read, blend, opacity and output registers.
// One word per cycle unless req_stall is high; divider, mask store and blend are pipelined.
// The four neighbours come from two copies of the mask store, each read at two addresses.
// A two-word output buffer lets one more result arrive while the output is stalled.
// Reset is synchronous: config and valid flags reset, the mask store keeps its contents.
module glyph_bilinear_scaler
  import gbs_pkg::*;
#(
  parameter int MAX_GLYPH_WIDTH  = 64,
  parameter int MAX_GLYPH_HEIGHT = 64,
  parameter int FRAC_BITS        = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  req_word_t            req,
  output logic                 res_valid,
  input  logic                 res_stall,
  output res_word_t            res
);

  localparam int DEPTH = MAX_GLYPH_WIDTH * MAX_GLYPH_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int QB    = SRC_W + FRAC_BITS;
  localparam int LO_W  = COORD_W + 1 + SRC_W;
  localparam int NUM_W = LO_W + FRAC_BITS;
  localparam int DEN_W = DST_W + 1;
  localparam int IDX_W = 2 * SRC_W + 1;
  localparam int RW    = ALPHA_W + FRAC_BITS;
  localparam int VW    = ALPHA_W + 2 * FRAC_BITS;
  localparam int MW    = VW + OPA_W;
  localparam int L     = QB + 1;

  logic [SRC_W-1:0] src_width;
  logic [SRC_W-1:0] src_height;
  logic [DST_W-1:0] dst_width;
  logic [DST_W-1:0] dst_height;
  logic [OPA_W-1:0] glyph_opacity;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width     <= '0;
      src_height    <= '0;
      dst_width     <= DST_W'(1);
      dst_height    <= DST_W'(1);
      glyph_opacity <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SRC_WIDTH:  src_width     <= cfg_data[SRC_W-1:0];
        REG_SRC_HEIGHT: src_height    <= cfg_data[SRC_W-1:0];
        REG_DST_WIDTH:  dst_width     <= cfg_data[DST_W-1:0];
        REG_DST_HEIGHT: dst_height    <= cfg_data[DST_W-1:0];
        REG_OPACITY:    glyph_opacity <= cfg_data[OPA_W-1:0];
        default: ;
      endcase
    end
  end

  logic      en;
  logic      skid_valid;
  res_word_t skid;

  assign en        = !skid_valid;
  assign req_stall = skid_valid;

  logic      s0_valid;
  req_word_t s0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0 <= req;
    end
  end

  logic [DST_W-1:0] dw_eff, dh_eff;
  logic [LO_W-1:0]  lo_x, lo_y;
  logic [NUM_W-1:0] num_x, num_y;

  assign dw_eff = (dst_width == '0) ? DST_W'(1) : dst_width;
  assign dh_eff = (dst_height == '0) ? DST_W'(1) : dst_height;
  assign lo_x   = LO_W'({s0.dst_x, 1'b1}) * LO_W'(src_width);
  assign lo_y   = LO_W'({s0.dst_y, 1'b1}) * LO_W'(src_height);
  assign num_x  = (lo_x < LO_W'(dw_eff)) ? '0 : NUM_W'(lo_x - LO_W'(dw_eff)) << FRAC_BITS;
  assign num_y  = (lo_y < LO_W'(dh_eff)) ? '0 : NUM_W'(lo_y - LO_W'(dh_eff)) << FRAC_BITS;

  logic [QB-1:0] qx, qy;
  logic          satx, saty;

  gbs_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QB(QB)) u_div_x (
    .clk(clk), .en(en), .num(num_x), .den({dw_eff, 1'b0}), .q(qx), .sat(satx)
  );

  gbs_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QB(QB)) u_div_y (
    .clk(clk), .en(en), .num(num_y), .den({dh_eff, 1'b0}), .q(qy), .sat(saty)
  );

  logic  sv_valid [L];
  side_t side     [L];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < L; i++) begin
        sv_valid[i] <= 1'b0;
      end
    end else if (en) begin
      sv_valid[0] <= s0_valid;
      for (int i = 1; i < L; i++) begin
        sv_valid[i] <= sv_valid[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= '{mode: s0.mode, load_index: s0.load_index, alpha_byte: s0.alpha_byte};
      for (int i = 1; i < L; i++) begin
        side[i] <= side[i-1];
      end
    end
  end

  function automatic logic [QB-1:0] clamp_coord(input logic [QB-1:0] q, input logic sat,
                                                input logic [SRC_W-1:0] src);
    logic [QB-1:0] maxc;
    maxc = QB'(SRC_W'(src - SRC_W'(1))) << FRAC_BITS;
    return (sat || (q > maxc)) ? maxc : q;
  endfunction

  function automatic logic [SRC_W-1:0] next_pos(input logic [SRC_W-1:0] p,
                                                input logic [SRC_W-1:0] src);
    logic [SRC_W:0] pp;
    pp = {1'b0, p} + (SRC_W+1)'(1);
    return (pp < {1'b0, src}) ? pp[SRC_W-1:0] : SRC_W'(src - SRC_W'(1));
  endfunction

  logic [QB-1:0]        sx, sy;
  logic [SRC_W-1:0]     x0, y0, x1, y1;
  logic [IDX_W-1:0]     i00, i01, i10, i11;

  assign sx  = clamp_coord(qx, satx, src_width);
  assign sy  = clamp_coord(qy, saty, src_height);
  assign x0  = sx[QB-1:FRAC_BITS];
  assign y0  = sy[QB-1:FRAC_BITS];
  assign x1  = next_pos(x0, src_width);
  assign y1  = next_pos(y0, src_height);
  assign i00 = IDX_W'(y0) * IDX_W'(src_width) + IDX_W'(x0);
  assign i01 = IDX_W'(y0) * IDX_W'(src_width) + IDX_W'(x1);
  assign i10 = IDX_W'(y1) * IDX_W'(src_width) + IDX_W'(x0);
  assign i11 = IDX_W'(y1) * IDX_W'(src_width) + IDX_W'(x1);

  logic                 c_valid;
  side_t                c_side;
  logic [AW-1:0]        c_a00, c_a01, c_a10, c_a11;
  logic [3:0]           c_ok;
  logic [FRAC_BITS-1:0] c_fx, c_fy;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= sv_valid[L-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_side <= side[L-1];
      c_a00  <= AW'(i00);
      c_a01  <= AW'(i01);
      c_a10  <= AW'(i10);
      c_a11  <= AW'(i11);
      c_ok   <= {32'(i11) < 32'(DEPTH), 32'(i10) < 32'(DEPTH),
                 32'(i01) < 32'(DEPTH), 32'(i00) < 32'(DEPTH)};
      c_fx   <= sx[FRAC_BITS-1:0];
      c_fy   <= sy[FRAC_BITS-1:0];
    end
  end

  logic               st_we;
  logic [ALPHA_W-1:0] rd00, rd01, rd10, rd11;

  assign st_we = en && c_valid && (c_side.mode == MODE_LOAD)
                 && (32'(c_side.load_index) < 32'(DEPTH));

  gbs_ram #(.WIDTH(ALPHA_W), .DEPTH(DEPTH)) u_store_top (
    .clk(clk), .we(st_we), .waddr(AW'(c_side.load_index)), .wdata(c_side.alpha_byte),
    .re(en), .raddr_a(c_a00), .raddr_b(c_a01), .rdata_a(rd00), .rdata_b(rd01)
  );

  gbs_ram #(.WIDTH(ALPHA_W), .DEPTH(DEPTH)) u_store_bot (
    .clk(clk), .we(st_we), .waddr(AW'(c_side.load_index)), .wdata(c_side.alpha_byte),
    .re(en), .raddr_a(c_a10), .raddr_b(c_a11), .rdata_a(rd10), .rdata_b(rd11)
  );

  logic                 d_valid;
  logic [3:0]           d_ok;
  logic [FRAC_BITS-1:0] d_fx, d_fy;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= c_valid && (c_side.mode == MODE_SAMPLE);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_ok <= c_ok;
      d_fx <= c_fx;
      d_fy <= c_fy;
    end
  end

  logic [ALPHA_W-1:0]   a00, a01, a10, a11;
  logic [FRAC_BITS:0]   wx1, wx0;
  logic [RW-1:0]        r0, r1;

  assign a00 = d_ok[0] ? rd00 : '0;
  assign a01 = d_ok[1] ? rd01 : '0;
  assign a10 = d_ok[2] ? rd10 : '0;
  assign a11 = d_ok[3] ? rd11 : '0;
  assign wx1 = {1'b0, d_fx};
  assign wx0 = {1'b1, {FRAC_BITS{1'b0}}} - wx1;
  assign r0  = RW'(a00) * RW'(wx0) + RW'(a01) * RW'(wx1);
  assign r1  = RW'(a10) * RW'(wx0) + RW'(a11) * RW'(wx1);

  logic                 e_valid;
  logic [RW-1:0]        e_r0, e_r1;
  logic [FRAC_BITS-1:0] e_fy;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (en) begin
      e_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_r0 <= r0;
      e_r1 <= r1;
      e_fy <= d_fy;
    end
  end

  logic [FRAC_BITS:0] wy1, wy0;
  logic [VW-1:0]      v;

  assign wy1 = {1'b0, e_fy};
  assign wy0 = {1'b1, {FRAC_BITS{1'b0}}} - wy1;
  assign v   = VW'(e_r0) * VW'(wy0) + VW'(e_r1) * VW'(wy1);

  logic          f_valid;
  logic [VW-1:0] f_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (en) begin
      f_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_v <= v;
    end
  end

  logic          g_valid;
  logic [MW-1:0] g_m;
  logic          g_nz;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else if (en) begin
      g_valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_m  <= MW'(f_v) * MW'(glyph_opacity);
      g_nz <= f_v != '0;
    end
  end

  logic [MW-1:0] g_t;
  logic [31:0]   g_u;
  logic [31:0]   g_q;
  logic          empty;
  res_word_t     g_res;

  assign g_t   = g_m + (MW'(255) << (2 * FRAC_BITS - 1));
  assign g_u   = 32'(g_t[MW-1:2*FRAC_BITS]);
  assign g_q   = g_u * 32'h0000_8081;
  assign empty = (src_width == '0) || (src_height == '0);
  assign g_res = '{coverage: empty ? 8'd0 : g_q[30:23], covered: !empty && g_nz};

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (!res_stall) begin
        res_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (res_valid && res_stall) begin
      skid_valid <= g_valid;
    end else begin
      res_valid <= g_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (!res_stall) begin
        res <= skid;
      end
    end else if (res_valid && res_stall) begin
      skid <= g_res;
    end else begin
      res <= g_res;
    end
  end

  a_skid_backed: assert property (@(posedge clk) disable iff (rst) skid_valid |-> res_valid)
    else $error("output buffer holds a word while the output register is empty");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && ((src_width == '0) || (src_height == '0)))
      |-> (res.coverage == 8'd0 && !res.covered))
    else $error("empty mask produced nonzero coverage");

  a_uncovered_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.covered) |-> (res.coverage == 8'd0))
    else $error("uncovered pixel carries coverage");

endmodule

// ----- sim/tb_glyph_bilinear_scaler.sv -----
// Self-checking testbench of the glyph scaler: random loads and samples against a predictor.
`timescale 1ns / 100ps

module tb_glyph_bilinear_scaler;
  import gbs_pkg::*;

  localparam int DEPTH = 64 * 64;
  localparam int FB = 8;

  class coverage_scoreboard;
    bit [7:0] mask_mem [DEPTH];
    int unsigned sw, sh, dw, dh, opa;
    res_word_t pending[$];
    int errors;

    function new();
      sw = 0; sh = 0; dw = 1; dh = 1; opa = 255; errors = 0;
    endfunction

    function void set_reg(reg_index_t idx, int unsigned val);
      case (idx)
        REG_SRC_WIDTH: sw = val & 'h7F;
        REG_SRC_HEIGHT: sh = val & 'h7F;
        REG_DST_WIDTH: dw = val & 'h7FF;
        REG_DST_HEIGHT: dh = val & 'h7FF;
        REG_OPACITY: opa = val & 'hFF;
        default: ;
      endcase
    endfunction

    function longint unsigned src_coord(int unsigned d, int unsigned s, int unsigned n);
      longint unsigned lo, c, mx;
      if (n == 0) n = 1;
      lo = longint'(2 * d + 1) * s;
      if (lo < n) c = 0;
      else c = ((lo - n) << FB) / (longint'(n) * 2);
      mx = longint'(s - 1) << FB;
      if (c > mx) c = mx;
      return c;
    endfunction

    function longint unsigned texel(int unsigned col, int unsigned row);
      longint unsigned a;
      a = longint'(row) * sw + col;
      if (a >= DEPTH) return 0;
      return mask_mem[a];
    endfunction

    function void note_input(req_word_t w);
      longint unsigned cx, cy, fx, fy, r0, r1, v, den;
      int unsigned x0, y0, x1, y1;
      res_word_t e;
      if (w.mode == MODE_LOAD) begin
        if (w.load_index < DEPTH) mask_mem[w.load_index] = w.alpha_byte;
        return;
      end
      if (sw == 0 || sh == 0) begin
        e.coverage = 0; e.covered = 0;
        pending = {pending, e};
        return;
      end
      cx = src_coord(w.dst_x, sw, dw);
      cy = src_coord(w.dst_y, sh, dh);
      x0 = 32'(cx >> FB); y0 = 32'(cy >> FB);
      fx = cx & 'hFF; fy = cy & 'hFF;
      x1 = (x0 + 1 < sw) ? x0 + 1 : sw - 1;
      y1 = (y0 + 1 < sh) ? y0 + 1 : sh - 1;
      r0 = texel(x0, y0) * (256 - fx) + texel(x1, y0) * fx;
      r1 = texel(x0, y1) * (256 - fx) + texel(x1, y1) * fx;
      v = r0 * (256 - fy) + r1 * fy;
      den = 64'd255 << (2 * FB);
      e.coverage = 8'(((v * opa + den / 2) / den) & 'hFF);
      e.covered = (v != 0);
      pending = {pending, e};
    endfunction

    function void check_result(res_word_t got);
      res_word_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result cov=%0d flag=%0d", got.coverage, got.covered);
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        errors++;
        if (errors <= 10)
          $display("result mismatch: expected cov=%0d flag=%0d, got cov=%0d flag=%0d",
                   e.coverage, e.covered, got.coverage, got.covered);
      end
    endfunction
  endclass

  logic clk, rst, cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic req_valid, req_stall, res_valid, res_stall;
  req_word_t req;
  res_word_t res;

  coverage_scoreboard sb;
  int idle_pct;

  glyph_bilinear_scaler u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .res_valid(res_valid), .res_stall(res_stall), .res(res)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) sb.note_input(req);
      if (res_valid && !res_stall) sb.check_result(res);
    end
  end

  always @(negedge clk) begin
    res_stall <= !rst && ($urandom_range(99) < idle_pct);
  end

  task automatic write_reg(reg_index_t idx, int unsigned val);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val[CFG_W-1:0];
    @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic send_word(req_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      req_valid <= 0;
    end
    @(negedge clk);
    req_valid <= 1; req <= w;
    do @(posedge clk); while (req_stall);
  endtask

  task automatic end_burst();
    @(negedge clk);
    req_valid <= 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic load_byte(int unsigned a, int unsigned v);
    req_word_t w;
    w = $bits(req_word_t)'({$urandom, $urandom});
    w.mode = MODE_LOAD; w.load_index = a[LOAD_W-1:0]; w.alpha_byte = v[ALPHA_W-1:0];
    send_word(w);
  endtask

  task automatic sample(int unsigned x, int unsigned y);
    req_word_t w;
    w = $bits(req_word_t)'({$urandom, $urandom});
    w.mode = MODE_SAMPLE; w.dst_x = x[COORD_W-1:0]; w.dst_y = y[COORD_W-1:0];
    send_word(w);
  endtask

  task automatic setup(int unsigned sw, int unsigned sh, int unsigned dw, int unsigned dh,
                       int unsigned op);
    write_reg(REG_SRC_WIDTH, sw);
    write_reg(REG_SRC_HEIGHT, sh);
    write_reg(REG_DST_WIDTH, dw);
    write_reg(REG_DST_HEIGHT, dh);
    write_reg(REG_OPACITY, op);
  endtask

  // Fill the whole mask so any sample reads only written entries.
  task automatic fill_mask(int unsigned sw, int unsigned sh, bit extremes);
    for (int i = 0; i < sw * sh && i < DEPTH; i++)
      load_byte(i, extremes ? ((i & 1) ? 255 : 0) : $urandom_range(255));
    end_burst();
  endtask

  initial begin
    int unsigned sw, sh, dw, dh;
    sb = new();
    rst = 1; cfg_we = 0; cfg_index = REG_SRC_WIDTH; cfg_data = 0;
    req_valid = 0; req = '0; res_stall = 0; idle_pct = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    sample(0, 0);
    sample(1023, 1023);
    load_byte(4095, 255);
    end_burst();
    drain();

    setup(64, 2, 1024, 1024, 255);
    fill_mask(64, 2, 1);
    idle_pct = 33;
    sample(0, 0);
    sample(1023, 1023);
    sample(1023, 0);
    sample(512, 511);
    end_burst();
    drain();

    setup(3, 2, 0, 0, 0);
    fill_mask(3, 2, 0);
    sample(0, 0);
    sample(1023, 5);
    load_byte(4095, 7);
    end_burst();
    drain();
    setup(0, 5, 4, 4, 128);
    sample(2, 2);
    end_burst();
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      idle_pct = (ph == 5) ? 0 : 33;
      sw = $urandom_range(1, 10); sh = $urandom_range(1, 10);
      if (ph == 3) begin sw = 64; sh = 2; end
      dw = $urandom_range(0, 40); dh = $urandom_range(0, 40);
      if (ph == 7) begin dw = 1024; dh = 1; end
      setup(sw, sh, dw, dh, (ph == 2) ? 0 : $urandom_range(255));
      fill_mask(sw, sh, 0);
      for (int n = 0; n < 30; n++) begin
        if ($urandom_range(3) == 0) begin
          if ($urandom_range(7) == 0) load_byte($urandom_range(4095), $urandom_range(255));
          else load_byte($urandom_range(sw * sh - 1), $urandom_range(255));
        end else if ($urandom_range(9) == 0) begin
          sample($urandom_range(1023), $urandom_range(1023));
        end else begin
          sample($urandom_range(dw + 1), $urandom_range(dh + 1));
        end
      end
      end_burst();
      drain();
    end
    setup(64, 1, 1024, 1024, 255);
    sample(0, 0);
    end_burst();
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
